### sv/lud_pkg.sv
`timescale 1ns / 1ps
package lud_pkg;

   // working format: signed, 20 fractional bits, held within +-2^60
   localparam int Q_W    = 62;
   localparam int Q_FRAC = 20;
   localparam logic signed [Q_W-1:0] Q_LIM   = {1'b0, 1'b1, 60'b0};
   localparam logic signed [Q_W-1:0] OUT_MAX = 62'sd8388607;
   localparam logic signed [Q_W-1:0] OUT_MIN = -62'sd8388608;

   typedef enum logic [2:0] {
      REG_FOCAL_X       = 3'd0,
      REG_FOCAL_Y       = 3'd1,
      REG_CENTER_X      = 3'd2,
      REG_CENTER_Y      = 3'd3,
      REG_RADIAL_K1     = 3'd4,
      REG_RADIAL_K2     = 3'd5,
      REG_TANGENTIAL_P1 = 3'd6,
      REG_TANGENTIAL_P2 = 3'd7
   } lud_reg_type;

   // saturating add in the working format
   function automatic logic signed [Q_W-1:0] q_add(
      input logic signed [Q_W-1:0] a,
      input logic signed [Q_W-1:0] b
   );
      logic signed [Q_W:0] s;
      logic signed [Q_W:0] lim_w;
      logic signed [Q_W-1:0] r;
      lim_w = {Q_LIM[Q_W-1], Q_LIM};
      s = {a[Q_W-1], a} + {b[Q_W-1], b};
      if (s > lim_w) begin
         r = Q_LIM;
      end else if (s < -lim_w) begin
         r = -Q_LIM;
      end else begin
         r = s[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

### sv/lud_div.sv
`timescale 1ns / 1ps
module lud_div #(
   parameter int NW = 45
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] dividend,
   input  logic [23:0]   divisor,
   input  logic          neg,
   output logic [NW-1:0] quotient,
   output logic          quotient_neg
);

   logic [23:0]   rem_ff [NW];
   logic [23:0]   rem_in [NW];
   logic [NW-1:0] num_ff [NW];
   logic [NW-1:0] num_in [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [NW-1:0] quo_in [NW];
   logic          neg_ff [NW];
   logic          neg_in [NW];

   // one quotient bit per stage, restoring
   always_comb begin
      logic [23:0]   rs;
      logic [NW-1:0] ns;
      logic [NW-1:0] qs;
      logic [24:0]   trial;
      logic          ge;
      for (int i = 0; i < NW; i++) begin
         if (i == 0) begin
            rs        = '0;
            ns        = dividend;
            qs        = '0;
            neg_in[i] = neg;
         end else begin
            rs        = rem_ff[i-1];
            ns        = num_ff[i-1];
            qs        = quo_ff[i-1];
            neg_in[i] = neg_ff[i-1];
         end
         trial     = {rs, ns[NW-1]};
         ge        = (trial >= {1'b0, divisor});
         rem_in[i] = ge ? 24'(trial - {1'b0, divisor}) : trial[23:0];
         num_in[i] = ns << 1;
         quo_in[i] = {qs[NW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NW; i++) begin
            rem_ff[i] <= rem_in[i];
            num_ff[i] <= num_in[i];
            quo_ff[i] <= quo_in[i];
            neg_ff[i] <= neg_in[i];
         end
      end
   end

   assign quotient     = quo_ff[NW-1];
   assign quotient_neg = neg_ff[NW-1];

endmodule

### sv/lud_mul.sv
`timescale 1ns / 1ps
module lud_mul import lud_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [Q_W-1:0] op_a,
   input  logic signed [Q_W-1:0] op_b,
   output logic signed [Q_W-1:0] prod
);

   localparam int MW = Q_W - 1;
   localparam int HW = MW - 32;
   localparam int PW = 2 * MW;
   localparam int SW = PW - Q_FRAC;

   logic [Q_W-1:0]       ua;
   logic [Q_W-1:0]       ub;
   logic [63:0]          ll_in, ll_ff, ll2_ff;
   logic [32+HW-1:0]     lh_in, lh_ff;
   logic [32+HW-1:0]     hl_in, hl_ff;
   logic [2*HW-1:0]      hh_in, hh_ff, hh2_ff;
   logic                 neg_in, neg1_ff, neg2_ff, neg3_ff;
   logic [32+HW:0]       mid_in, mid_ff;
   logic [PW-1:0]        pr_in, pr_ff;
   logic [SW-1:0]        sh;
   logic [SW-1:0]        lim_w;
   logic [MW-1:0]        mag;
   logic signed [Q_W-1:0] prod_in, prod_ff;

   always_comb begin
      ua     = op_a[Q_W-1] ? Q_W'(-op_a) : op_a;
      ub     = op_b[Q_W-1] ? Q_W'(-op_b) : op_b;
      neg_in = op_a[Q_W-1] ^ op_b[Q_W-1];
      // partial products
      ll_in  = 64'(ua[31:0]) * 64'(ub[31:0]);
      lh_in  = (32+HW)'(ua[31:0]) * (32+HW)'(ub[MW-1:32]);
      hl_in  = (32+HW)'(ua[MW-1:32]) * (32+HW)'(ub[31:0]);
      hh_in  = (2*HW)'(ua[MW-1:32]) * (2*HW)'(ub[MW-1:32]);
      mid_in = (33+HW)'(lh_ff) + (33+HW)'(hl_ff);
      // full product plus half lsb
      pr_in  = {hh2_ff, ll2_ff} + (PW'(mid_ff) << 32) + (PW'(1) << (Q_FRAC - 1));
      sh     = pr_ff[PW-1:Q_FRAC];
      lim_w  = SW'(Q_LIM);
      mag    = (sh > lim_w) ? MW'(Q_LIM) : sh[MW-1:0];
      prod_in = neg3_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
         neg1_ff <= neg_in;
         mid_ff  <= mid_in;
         ll2_ff  <= ll_ff;
         hh2_ff  <= hh_ff;
         neg2_ff <= neg1_ff;
         pr_ff   <= pr_in;
         neg3_ff <= neg2_ff;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

### sv/lens_undistort_map_generator.sv
`timescale 1ns / 1ps
// Lens undistortion map generator.
// Request channel: req_valid / req_stall with req_pixel_col and req_pixel_row,
// one output pixel coordinate per request.
// Response channel: rsp_valid / rsp_stall with rsp_map_x, rsp_map_y (signed,
// 8 fractional bits, saturated) and rsp_clipped.
// Register port: csr_valid / csr_ready with csr_index and csr_data; always
// ready. Registers must be written only while no request is in flight;
// the block does not enforce this. Throughput: one request per cycle while
// not stalled. Datapath: the pipelined restoring lift divider (45 - SCALE_LOG2
// stages) followed by five chained multiplies of four stages each.
// Reset: synchronous; empties the pipeline and restores register defaults
// (focal lengths 256, all else 0).
// Stall: when the response register holds a result and rsp_stall is high,
// the whole pipeline holds and req_stall is raised; nothing is lost.
module lens_undistort_map_generator import lud_pkg::*; #(
   parameter int SCALE_LOG2 = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_pixel_col,
   input  logic [11:0]        req_pixel_row,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_map_x,
   output logic signed [23:0] rsp_map_y,
   output logic               rsp_clipped,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data
);

   localparam int LIFT_SH = 20 - SCALE_LOG2;
   localparam int NW      = 25 + LIFT_SH;
   localparam int XW      = NW + 1;
   localparam int LAT     = NW + 29;

   typedef struct packed {
      logic signed [Q_W-1:0] pxy_x;
      logic signed [Q_W-1:0] pxy_y;
      logic signed [Q_W-1:0] pt_x;
      logic signed [Q_W-1:0] pt_y;
   } lud_tan_type;

   // registers
   logic [23:0] focal_x_ff, focal_x_in, focal_y_ff, focal_y_in;
   logic [23:0] center_x_ff, center_x_in, center_y_ff, center_y_in;
   logic [23:0] k1_ff, k1_in, k2_ff, k2_in, p1_ff, p1_in, p2_ff, p2_in;

   logic [23:0] fx_eff, fy_eff;
   logic signed [Q_W-1:0] k1_q, k2_q, p1_q, p2_q, fx_q, fy_q, cx_q, cy_q;

   logic           adv;
   logic [LAT-1:0] vld_ff, vld_in;

   // lift
   logic signed [24:0] numx, numy;
   logic [23:0]        magx, magy;
   logic [NW-1:0]      nx_ff, nx_in, ny_ff, ny_in;
   logic               sx_ff, sx_in, sy_ff, sy_in;
   logic [NW-1:0]      qx, qy;
   logic               qx_neg, qy_neg;
   logic signed [XW-1:0] xs, ys;
   logic signed [Q_W-1:0] xq, yq;

   logic signed [XW-1:0] xd_ff [21];
   logic signed [XW-1:0] xd_in [21];
   logic signed [XW-1:0] yd_ff [21];
   logic signed [XW-1:0] yd_in [21];

   logic signed [Q_W-1:0] x2, y2, xy;
   logic signed [Q_W-1:0] r2_ff, r2_in, xy2_ff, xy2_in, x2d_ff, x2d_in, y2d_ff, y2d_in;
   logic signed [Q_W-1:0] tx_ff, tx_in, ty_ff, ty_in, r2b_ff, r2b_in, xy2b_ff, xy2b_in;
   logic signed [Q_W-1:0] r4, k1r2, p1xy2, p2xy2, p2tx, p1ty, k2r4;
   lud_tan_type           tan_ff [10];
   lud_tan_type           tan_in [10];
   logic signed [Q_W-1:0] k1d_ff [4];
   logic signed [Q_W-1:0] k1d_in [4];
   logic signed [Q_W-1:0] rad_ff, rad_in;
   logic signed [Q_W-1:0] xrad, yrad, xl_q, yl_q, xe_q, ye_q;
   logic signed [Q_W-1:0] sxd_ff, sxd_in, syd_ff, syd_in;
   logic signed [Q_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [Q_W-1:0] pdx_ff, pdx_in, pdy_ff, pdy_in;
   logic signed [Q_W-1:0] fpx, fpy;
   logic signed [Q_W-1:0] vx_ff, vx_in, vy_ff, vy_in;

   logic signed [23:0] map_x_ff, map_x_in, map_y_ff, map_y_in;
   logic               clip_ff, clip_in, clip_x, clip_y;

   // register port
   assign csr_ready = 1'b1;

   always_comb begin
      focal_x_in  = focal_x_ff;
      focal_y_in  = focal_y_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      k1_in       = k1_ff;
      k2_in       = k2_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      if (csr_valid && csr_ready) begin
         case (lud_reg_type'(csr_index))
            REG_FOCAL_X:       focal_x_in  = csr_data;
            REG_FOCAL_Y:       focal_y_in  = csr_data;
            REG_CENTER_X:      center_x_in = csr_data;
            REG_CENTER_Y:      center_y_in = csr_data;
            REG_RADIAL_K1:     k1_in       = csr_data;
            REG_RADIAL_K2:     k2_in       = csr_data;
            REG_TANGENTIAL_P1: p1_in       = csr_data;
            REG_TANGENTIAL_P2: p2_in       = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 24'd256;
         focal_y_ff  <= 24'd256;
         center_x_ff <= '0;
         center_y_ff <= '0;
         k1_ff       <= '0;
         k2_ff       <= '0;
         p1_ff       <= '0;
         p2_ff       <= '0;
      end else begin
         focal_x_ff  <= focal_x_in;
         focal_y_ff  <= focal_y_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         k1_ff       <= k1_in;
         k2_ff       <= k2_in;
         p1_ff       <= p1_in;
         p2_ff       <= p2_in;
      end
   end

   // zero focal length acts as one lsb
   assign fx_eff = (focal_x_ff == '0) ? 24'd1 : focal_x_ff;
   assign fy_eff = (focal_y_ff == '0) ? 24'd1 : focal_y_ff;
   assign k1_q   = {{(Q_W-24){k1_ff[23]}}, k1_ff};
   assign k2_q   = {{(Q_W-24){k2_ff[23]}}, k2_ff};
   assign p1_q   = {{(Q_W-24){p1_ff[23]}}, p1_ff};
   assign p2_q   = {{(Q_W-24){p2_ff[23]}}, p2_ff};
   assign fx_q   = {{(Q_W-24){1'b0}}, fx_eff};
   assign fy_q   = {{(Q_W-24){1'b0}}, fy_eff};
   assign cx_q   = {{(Q_W-24){1'b0}}, center_x_ff};
   assign cy_q   = {{(Q_W-24){1'b0}}, center_y_ff};

   // pipeline advance
   assign adv       = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // lift: rounded dividend
   always_comb begin
      numx  = $signed({5'b0, req_pixel_col, 8'b0}) - $signed({1'b0, center_x_ff});
      numy  = $signed({5'b0, req_pixel_row, 8'b0}) - $signed({1'b0, center_y_ff});
      magx  = numx[24] ? 24'(-numx) : numx[23:0];
      magy  = numy[24] ? 24'(-numy) : numy[23:0];
      nx_in = (NW'(magx) << LIFT_SH) + NW'(fx_eff[23:1]);
      ny_in = (NW'(magy) << LIFT_SH) + NW'(fy_eff[23:1]);
      sx_in = numx[24];
      sy_in = numy[24];
   end

   lud_div #(.NW(NW)) u_div_x (
      .clock        (clock),
      .en           (adv),
      .dividend     (nx_ff),
      .divisor      (fx_eff),
      .neg          (sx_ff),
      .quotient     (qx),
      .quotient_neg (qx_neg)
   );

   lud_div #(.NW(NW)) u_div_y (
      .clock        (clock),
      .en           (adv),
      .dividend     (ny_ff),
      .divisor      (fy_eff),
      .neg          (sy_ff),
      .quotient     (qy),
      .quotient_neg (qy_neg)
   );

   assign xs = qx_neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
   assign ys = qy_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
   assign xq = Q_W'(xs);
   assign yq = Q_W'(ys);

   // squares and cross term
   lud_mul u_m_xx (.clock(clock), .en(adv), .op_a(xq), .op_b(xq), .prod(x2));
   lud_mul u_m_yy (.clock(clock), .en(adv), .op_a(yq), .op_b(yq), .prod(y2));
   lud_mul u_m_xy (.clock(clock), .en(adv), .op_a(xq), .op_b(yq), .prod(xy));

   always_comb begin
      r2_in   = q_add(x2, y2);
      xy2_in  = q_add(xy, xy);
      x2d_in  = q_add(x2, x2);
      y2d_in  = q_add(y2, y2);
      tx_in   = q_add(r2_ff, x2d_ff);
      ty_in   = q_add(r2_ff, y2d_ff);
      r2b_in  = r2_ff;
      xy2b_in = xy2_ff;
   end

   lud_mul u_m_r4  (.clock(clock), .en(adv), .op_a(r2b_ff), .op_b(r2b_ff), .prod(r4));
   lud_mul u_m_k1  (.clock(clock), .en(adv), .op_a(k1_q), .op_b(r2b_ff), .prod(k1r2));
   lud_mul u_m_p1x (.clock(clock), .en(adv), .op_a(p1_q), .op_b(xy2b_ff), .prod(p1xy2));
   lud_mul u_m_p2x (.clock(clock), .en(adv), .op_a(p2_q), .op_b(xy2b_ff), .prod(p2xy2));
   lud_mul u_m_p2t (.clock(clock), .en(adv), .op_a(p2_q), .op_b(tx_ff), .prod(p2tx));
   lud_mul u_m_p1t (.clock(clock), .en(adv), .op_a(p1_q), .op_b(ty_ff), .prod(p1ty));
   lud_mul u_m_k2  (.clock(clock), .en(adv), .op_a(k2_q), .op_b(r4), .prod(k2r4));

   assign xl_q = Q_W'(xd_ff[14]);
   assign yl_q = Q_W'(yd_ff[14]);
   assign xe_q = Q_W'(xd_ff[20]);
   assign ye_q = Q_W'(yd_ff[20]);

   lud_mul u_m_xr (.clock(clock), .en(adv), .op_a(xl_q), .op_b(rad_ff), .prod(xrad));
   lud_mul u_m_yr (.clock(clock), .en(adv), .op_a(yl_q), .op_b(rad_ff), .prod(yrad));
   lud_mul u_m_fx (.clock(clock), .en(adv), .op_a(fx_q), .op_b(pdx_ff), .prod(fpx));
   lud_mul u_m_fy (.clock(clock), .en(adv), .op_a(fy_q), .op_b(pdy_ff), .prod(fpy));

   // delay lines and late sums
   always_comb begin
      for (int i = 0; i < 21; i++) begin
         xd_in[i] = (i == 0) ? xs : xd_ff[(i == 0) ? 0 : i - 1];
         yd_in[i] = (i == 0) ? ys : yd_ff[(i == 0) ? 0 : i - 1];
      end
      for (int i = 0; i < 10; i++) begin
         if (i == 0) begin
            tan_in[i].pxy_x = p1xy2;
            tan_in[i].pxy_y = p2xy2;
            tan_in[i].pt_x  = p2tx;
            tan_in[i].pt_y  = p1ty;
         end else begin
            tan_in[i] = tan_ff[i-1];
         end
      end
      for (int i = 0; i < 4; i++) begin
         k1d_in[i] = (i == 0) ? k1r2 : k1d_ff[(i == 0) ? 0 : i - 1];
      end
      rad_in = q_add(k1d_ff[3], k2r4);
      sxd_in = q_add(xrad, tan_ff[8].pxy_x);
      syd_in = q_add(yrad, tan_ff[8].pxy_y);
      dx_in  = q_add(sxd_ff, tan_ff[9].pt_x);
      dy_in  = q_add(syd_ff, tan_ff[9].pt_y);
      pdx_in = q_add(xe_q, dx_ff);
      pdy_in = q_add(ye_q, dy_ff);
      vx_in  = q_add(fpx, cx_q);
      vy_in  = q_add(fpy, cy_q);
   end

   // output saturation
   always_comb begin
      clip_x = 1'b0;
      clip_y = 1'b0;
      if (vx_ff > OUT_MAX) begin
         map_x_in = 24'h7fffff;
         clip_x   = 1'b1;
      end else if (vx_ff < OUT_MIN) begin
         map_x_in = 24'h800000;
         clip_x   = 1'b1;
      end else begin
         map_x_in = vx_ff[23:0];
      end
      if (vy_ff > OUT_MAX) begin
         map_y_in = 24'h7fffff;
         clip_y   = 1'b1;
      end else if (vy_ff < OUT_MIN) begin
         map_y_in = 24'h800000;
         clip_y   = 1'b1;
      end else begin
         map_y_in = vy_ff[23:0];
      end
      clip_in = clip_x | clip_y;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         for (int i = 0; i < 21; i++) begin
            xd_ff[i] <= xd_in[i];
            yd_ff[i] <= yd_in[i];
         end
         for (int i = 0; i < 10; i++) begin
            tan_ff[i] <= tan_in[i];
         end
         for (int i = 0; i < 4; i++) begin
            k1d_ff[i] <= k1d_in[i];
         end
         r2_ff    <= r2_in;
         xy2_ff   <= xy2_in;
         x2d_ff   <= x2d_in;
         y2d_ff   <= y2d_in;
         tx_ff    <= tx_in;
         ty_ff    <= ty_in;
         r2b_ff   <= r2b_in;
         xy2b_ff  <= xy2b_in;
         rad_ff   <= rad_in;
         sxd_ff   <= sxd_in;
         syd_ff   <= syd_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         pdx_ff   <= pdx_in;
         pdy_ff   <= pdy_in;
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
         map_x_ff <= map_x_in;
         map_y_ff <= map_y_in;
         clip_ff  <= clip_in;
      end
   end

   assign rsp_valid   = vld_ff[LAT-1];
   assign rsp_map_x   = map_x_ff;
   assign rsp_map_y   = map_y_ff;
   assign rsp_clipped = clip_ff;

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("pipeline accepts a request while the response is stalled");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> (rsp_map_x == 24'sh7fffff || rsp_map_x == -24'sh800000 ||
                                    rsp_map_y == 24'sh7fffff || rsp_map_y == -24'sh800000))
      else $error("clipped flag set without a saturated coordinate");

   a_entry_valid: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");
`endif

endmodule
